@@ rtl/pfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the palette fade and flash blender: op and
// mode codes, register indexes, level constants and the queue word layout.
// ----------------------------------------------------------------------------
package pfb_pkg;

	// Input op codes
	localparam logic [1:0] OP_COLOUR  = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Effect modes
	localparam logic [2:0] MODE_FADE_IN   = 3'd0;
	localparam logic [2:0] MODE_FADE_OUT  = 3'd1;
	localparam logic [2:0] MODE_WHITE_IN  = 3'd2;
	localparam logic [2:0] MODE_WHITE_OUT = 3'd3;
	localparam logic [2:0] MODE_FLASH     = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_RED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_GREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BLUE  = 3'd4;

	localparam logic [15:0] DURATION_RESET = 16'd1000;

	// Level arithmetic, 1/1024 units
	localparam int LVL_W      = 13;
	localparam int STEP_FRAC  = 10;
	localparam int MS_W       = 8;
	localparam int DIV_BITS   = MS_W + STEP_FRAC;
	localparam int STEP_W     = 12;
	localparam int STEP_MAX   = 2048;

	localparam logic signed [LVL_W-1:0] LVL_START_FADE_IN   = 13'sd1536;
	localparam logic signed [LVL_W-1:0] LVL_START_FADE_OUT  = -13'sd3072;
	localparam logic signed [LVL_W-1:0] LVL_START_WHITE_IN  = 13'sd1536;
	localparam logic signed [LVL_W-1:0] LVL_START_WHITE_OUT = 13'sd0;
	localparam logic signed [LVL_W-1:0] LVL_START_FLASH     = -13'sd1024;

	// Class of a queued word
	typedef enum logic [1:0] {
		KIND_COLOUR  = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [MS_W-1:0] frame_ms;
	} entry_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] duration_ms;
		logic [7:0]  flash_red;
		logic [7:0]  flash_green;
		logic [7:0]  flash_blue;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/pfb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_front
// Input side: accepts words, classifies them by op, drops the unused op and
// queues the rest in a small flip-flop queue for the back end.
// ----------------------------------------------------------------------------
module pfb_front #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [1:0]          op,
	input  wire logic [7:0]          red_in,
	input  wire logic [7:0]          green_in,
	input  wire logic [7:0]          blue_in,
	input  wire logic [7:0]          frame_ms,
	output      pfb_pkg::entry_t     head,
	output      logic                head_valid,
	input  wire logic                pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfb_pkg::entry_t   entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	pfb_pkg::entry_t   word;
	logic              keep;
	logic              push;

	// Classify the incoming word
	always_comb begin
		word.red      = red_in;
		word.green    = green_in;
		word.blue     = blue_in;
		word.frame_ms = frame_ms;
		word.kind     = pfb_pkg::KIND_COLOUR;
		keep          = 1'b1;
		unique case (op)
			pfb_pkg::OP_COLOUR:  word.kind = pfb_pkg::KIND_COLOUR;
			pfb_pkg::OP_TICK:    word.kind = pfb_pkg::KIND_TICK;
			pfb_pkg::OP_RESTART: word.kind = pfb_pkg::KIND_RESTART;
			default:             keep      = 1'b0;
		endcase
	end

	assign in_stall   = (count_q == CNT_W'(DEPTH));
	assign push       = in_valid && !in_stall && keep;
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Store words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/pfb_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_div
// Step divider: (frame_ms << 10) / duration_ms, one quotient bit a cycle,
// clamped to the largest step. A zero divisor yields the largest step.
// ----------------------------------------------------------------------------
module pfb_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pfb_pkg::MS_W-1:0]    dividend,
	input  wire logic [15:0]                 divisor,
	output      logic                        done,
	output      logic [pfb_pkg::STEP_W-1:0]  step
);

	localparam int NB    = pfb_pkg::DIV_BITS;
	localparam int CNT_W = $clog2(NB);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NB-1:0]    num_q;
	logic [NB-1:0]    quo_q;
	logic [15:0]      rem_q;
	logic [16:0]      trial;
	logic [16:0]      diff;
	logic             ge;

	// Trial subtract for one quotient bit
	always_comb begin
		trial = {rem_q, num_q[NB-1]};
		ge    = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift dividend, remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, pfb_pkg::STEP_FRAC'(0)};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

	assign done = done_q;
	assign step = (quo_q > NB'(pfb_pkg::STEP_MAX)) ? pfb_pkg::STEP_W'(pfb_pkg::STEP_MAX)
	                                               : quo_q[pfb_pkg::STEP_W-1:0];

endmodule
`default_nettype wire

@@ rtl/pfb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_back
// Execution side: holds the effect level, blends colour words in two stages
// (weights and products, then sum and scale), runs ticks through the step
// divider and loads start levels on restart.
// ----------------------------------------------------------------------------
module pfb_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pfb_pkg::cfg_t    cfg,
	input  wire pfb_pkg::entry_t  head,
	input  wire logic             head_valid,
	output      logic             pop,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [7:0]       red_out,
	output      logic [7:0]       green_out,
	output      logic [7:0]       blue_out
);

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_WAIT = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		XS_COLOUR = 2'd0,
		XS_COMPL  = 2'd1,
		XS_ZERO   = 2'd2
	} xsel_t;

	localparam logic signed [13:0] ONE  = 14'sd1024;
	localparam logic signed [13:0] LMIN = -14'sd4096;
	localparam logic signed [13:0] LMAX = 14'sd4095;

	state_t                          state_q;
	logic signed [pfb_pkg::LVL_W-1:0] level_q;
	logic                            s1_vld_s1;
	logic [18:0]                     prod_a_s1 [3];
	logic [18:0]                     prod_b_s1 [3];
	logic                            inv_s1;
	logic                            out_vld_q;
	logic [7:0]                      res_q [3];

	logic signed [13:0]  lvl_x;
	logic signed [13:0]  one_minus;
	logic signed [13:0]  lvl_clip;
	logic signed [13:0]  neg_clip;
	logic signed [13:0]  flash_w;
	logic [10:0]         w1;
	logic [10:0]         w2;
	logic                inv;
	xsel_t               xs;
	logic [7:0]          c_in [3];
	logic [7:0]          f_in [3];
	logic [7:0]          x_in [3];
	logic [18:0]         prod_a [3];
	logic [18:0]         prod_b [3];
	logic [19:0]         sum [3];
	logic [7:0]          res [3];

	logic                out_free;
	logic                s1_adv;
	logic                s1_free;
	logic                pop_colour;
	logic                div_start;
	logic                div_done;
	logic [pfb_pkg::STEP_W-1:0] step;
	logic signed [13:0]  step_x;
	logic signed [13:0]  tick_sum;
	logic signed [13:0]  tick_sat;
	logic signed [pfb_pkg::LVL_W-1:0] restart_level;

	// Handshake between stages
	assign out_free   = !out_vld_q || !out_stall;
	assign s1_adv     = s1_vld_s1 && out_free;
	assign s1_free    = !s1_vld_s1 || s1_adv;
	assign pop        = head_valid && (state_q == ST_RUN) &&
	                    ((head.kind != pfb_pkg::KIND_COLOUR) || s1_free);
	assign pop_colour = pop && (head.kind == pfb_pkg::KIND_COLOUR);
	assign div_start  = pop && (head.kind == pfb_pkg::KIND_TICK);

	// Blend weights from level and mode
	always_comb begin
		lvl_x     = {level_q[pfb_pkg::LVL_W-1], level_q};
		one_minus = ONE - lvl_x;
		lvl_clip  = (lvl_x < -ONE) ? -ONE : lvl_x;
		neg_clip  = -lvl_clip;
		flash_w   = lvl_clip + ONE;
		w1        = 11'd1024;
		w2        = '0;
		inv       = 1'b0;
		xs        = XS_COLOUR;
		case (cfg.mode) inside
			pfb_pkg::MODE_FADE_IN, pfb_pkg::MODE_FADE_OUT: begin
				if (lvl_x > ONE) begin
					xs = XS_ZERO;
				end else if (lvl_x > 14'sd0) begin
					w1 = one_minus[10:0];
				end
			end
			pfb_pkg::MODE_WHITE_IN, pfb_pkg::MODE_WHITE_OUT: begin
				if (lvl_x > ONE) begin
					xs  = XS_ZERO;
					inv = 1'b1;
				end else if (lvl_x > 14'sd0) begin
					xs  = XS_COMPL;
					inv = 1'b1;
					w1  = one_minus[10:0];
				end
			end
			pfb_pkg::MODE_FLASH: begin
				if (lvl_x < 14'sd0) begin
					w1 = neg_clip[10:0];
					w2 = flash_w[10:0];
				end else if (lvl_x < ONE) begin
					w1 = lvl_x[10:0];
					w2 = one_minus[10:0];
				end
			end
			default: ;
		endcase
	end

	// Products per component
	always_comb begin
		c_in[0] = head.red;
		c_in[1] = head.green;
		c_in[2] = head.blue;
		f_in[0] = cfg.flash_red;
		f_in[1] = cfg.flash_green;
		f_in[2] = cfg.flash_blue;
		for (int i = 0; i < 3; i++) begin
			case (xs)
				XS_COMPL: x_in[i] = 8'd255 - c_in[i];
				XS_ZERO:  x_in[i] = '0;
				default:  x_in[i] = c_in[i];
			endcase
			prod_a[i] = {11'd0, x_in[i]} * {8'd0, w1};
			prod_b[i] = {11'd0, f_in[i]} * {8'd0, w2};
		end
	end

	// Sum, scale and optional complement
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {1'b0, prod_a_s1[i]} + {1'b0, prod_b_s1[i]};
			res[i] = inv_s1 ? (8'd255 - sum[i][17:10]) : sum[i][17:10];
		end
	end

	// Tick: move the level by the step under the mode's rule
	always_comb begin
		step_x   = {2'b00, step};
		tick_sum = lvl_x;
		case (cfg.mode) inside
			pfb_pkg::MODE_FADE_IN, pfb_pkg::MODE_WHITE_IN: begin
				if (lvl_x > 14'sd0) tick_sum = lvl_x - step_x;
			end
			pfb_pkg::MODE_FADE_OUT, pfb_pkg::MODE_WHITE_OUT: begin
				if (lvl_x <= ONE) tick_sum = lvl_x + step_x;
			end
			pfb_pkg::MODE_FLASH: begin
				if (lvl_x < ONE) tick_sum = lvl_x + step_x;
			end
			default: ;
		endcase
		if (tick_sum < LMIN) begin
			tick_sat = LMIN;
		end else if (tick_sum > LMAX) begin
			tick_sat = LMAX;
		end else begin
			tick_sat = tick_sum;
		end
	end

	// Restart: load the mode's start level
	always_comb begin
		unique case (cfg.mode)
			pfb_pkg::MODE_FADE_IN:   restart_level = pfb_pkg::LVL_START_FADE_IN;
			pfb_pkg::MODE_FADE_OUT:  restart_level = pfb_pkg::LVL_START_FADE_OUT;
			pfb_pkg::MODE_WHITE_IN:  restart_level = pfb_pkg::LVL_START_WHITE_IN;
			pfb_pkg::MODE_WHITE_OUT: restart_level = pfb_pkg::LVL_START_WHITE_OUT;
			pfb_pkg::MODE_FLASH:     restart_level = pfb_pkg::LVL_START_FLASH;
			default:                 restart_level = level_q;
		endcase
	end

	pfb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.frame_ms),
		.divisor  (cfg.duration_ms),
		.done     (div_done),
		.step     (step)
	);

	// Control: state, level, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			level_q   <= pfb_pkg::LVL_START_FADE_IN;
			s1_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN:  if (div_start) state_q <= ST_WAIT;
				ST_WAIT: if (div_done) state_q <= ST_RUN;
				default: state_q <= ST_RUN;
			endcase
			if ((state_q == ST_WAIT) && div_done) begin
				level_q <= tick_sat[pfb_pkg::LVL_W-1:0];
			end else if (pop && (head.kind == pfb_pkg::KIND_RESTART)) begin
				level_q <= restart_level;
			end
			s1_vld_s1 <= pop_colour || (s1_vld_s1 && !s1_adv);
			out_vld_q <= s1_adv || (out_vld_q && out_stall);
		end
	end

	// Payload: products and result word
	always_ff @(posedge clk) begin
		if (pop_colour) begin
			prod_a_s1 <= prod_a;
			prod_b_s1 <= prod_b;
			inv_s1    <= inv;
		end
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign red_out   = res_q[0];
	assign green_out = res_q[1];
	assign blue_out  = res_q[2];

endmodule
`default_nettype wire

@@ rtl/palette_fade_flash_blender.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// palette_fade_flash_blender
// Palette fade engine: fade in/out, white in/out and flash toward a set
// colour, driven by a signed effect level in 1/1024 units.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    op, red_in, green_in, blue_in,
//                                              frame_ms
//   out      source     out_valid / out_stall  red_out, green_out, blue_out
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Colour words flow one per cycle while the output is not stalled and no
// tick is in progress, through the queue, product stage and result register.
// A frame tick holds the back end while the step divider produces eighteen
// quotient bits; a restart does not hold it.
// The queue absorbs up to QUEUE_DEPTH words; in_stall rises when it is full.
// Reset loads register defaults and a level of 1536; no clearing pass.
// ----------------------------------------------------------------------------
module palette_fade_flash_blender #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [1:0]                        op,
	input  wire logic [7:0]                        red_in,
	input  wire logic [7:0]                        green_in,
	input  wire logic [7:0]                        blue_in,
	input  wire logic [7:0]                        frame_ms,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [7:0]                        red_out,
	output      logic [7:0]                        green_out,
	output      logic [7:0]                        blue_out,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [pfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pfb_pkg::cfg_t   cfg_q;
	pfb_pkg::entry_t head;
	logic            head_valid;
	logic            pop;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= pfb_pkg::MODE_FADE_IN;
			cfg_q.duration_ms <= pfb_pkg::DURATION_RESET;
			cfg_q.flash_red   <= '0;
			cfg_q.flash_green <= '0;
			cfg_q.flash_blue  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pfb_pkg::CFG_MODE:        cfg_q.mode        <= cfg_data[2:0];
				pfb_pkg::CFG_DURATION:    cfg_q.duration_ms <= cfg_data;
				pfb_pkg::CFG_FLASH_RED:   cfg_q.flash_red   <= cfg_data[7:0];
				pfb_pkg::CFG_FLASH_GREEN: cfg_q.flash_green <= cfg_data[7:0];
				pfb_pkg::CFG_FLASH_BLUE:  cfg_q.flash_blue  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pfb_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.frame_ms   (frame_ms),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	pfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out)
	);

endmodule
`default_nettype wire

@@ verif/pfb_blend_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_blend_checker
// Watches the input, configuration and output channels of the palette fade
// and flash blender. It keeps its own copy of the registers and the effect
// level, predicts the blended colour of every accepted colour word and
// compares each accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module pfb_blend_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [1:0]                     op,
	input  wire logic [7:0]                     red_in,
	input  wire logic [7:0]                     green_in,
	input  wire logic [7:0]                     blue_in,
	input  wire logic [7:0]                     frame_ms,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [7:0]                     red_out,
	input  wire logic [7:0]                     green_out,
	input  wire logic [7:0]                     blue_out,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  mismatches,
	output int                                  colours_pending
);
	import pfb_pkg::*;

	localparam int LVL_ONE = 1024;
	localparam int LVL_MIN = -4096;
	localparam int LVL_MAX = 4095;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	cfg_t                     regs;
	logic signed [LVL_W-1:0]  level;
	colour_t                  colours_due[$];

	// Blend one component toward black, white or the flash colour
	function automatic logic [7:0] blend_component(input logic [7:0] c, input logic [7:0] f);
		int l;
		int ci;
		int fi;
		int r;
		l  = int'(level);
		ci = int'(c);
		fi = int'(f);
		case (regs.mode)
			MODE_FADE_IN, MODE_FADE_OUT: begin
				if (l > LVL_ONE)
					r = 0;
				else if (l > 0)
					r = (ci * (LVL_ONE - l)) >>> STEP_FRAC;
				else
					r = ci;
			end
			MODE_WHITE_IN, MODE_WHITE_OUT: begin
				if (l > LVL_ONE)
					r = 255;
				else if (l > 0)
					r = 255 - (((255 - ci) * (LVL_ONE - l)) >>> STEP_FRAC);
				else
					r = ci;
			end
			MODE_FLASH: begin
				// below -1024 the level counts as -1024, so the colour passes
				if (l < 0) begin
					if (l < -LVL_ONE)
						l = -LVL_ONE;
					r = (ci * (-l) + fi * (l + LVL_ONE)) >>> STEP_FRAC;
				end else if (l < LVL_ONE) begin
					r = (ci * l + fi * (LVL_ONE - l)) >>> STEP_FRAC;
				end else begin
					r = ci;
				end
			end
			default: r = ci;
		endcase
		return r[7:0];
	endfunction

	// Move the level by one frame under the mode's rule, then saturate
	function automatic logic signed [LVL_W-1:0] level_after_tick(input logic [7:0] ms);
		int step;
		int l;
		l = int'(level);
		if (regs.duration_ms == 16'd0)
			step = STEP_MAX;
		else
			step = (int'(ms) << STEP_FRAC) / int'(regs.duration_ms);
		if (step > STEP_MAX)
			step = STEP_MAX;
		case (regs.mode)
			MODE_FADE_IN, MODE_WHITE_IN: begin
				if (l > 0)
					l = l - step;
			end
			MODE_FADE_OUT, MODE_WHITE_OUT: begin
				if (l <= LVL_ONE)
					l = l + step;
			end
			MODE_FLASH: begin
				if (l < LVL_ONE)
					l = l + step;
			end
			default: ;
		endcase
		if (l < LVL_MIN)
			l = LVL_MIN;
		if (l > LVL_MAX)
			l = LVL_MAX;
		return LVL_W'(l);
	endfunction

	// Start level of the current mode; unknown modes keep the level
	function automatic logic signed [LVL_W-1:0] start_level_of(input logic [2:0] m);
		case (m)
			MODE_FADE_IN:   return LVL_START_FADE_IN;
			MODE_FADE_OUT:  return LVL_START_FADE_OUT;
			MODE_WHITE_IN:  return LVL_START_WHITE_IN;
			MODE_WHITE_OUT: return LVL_START_WHITE_OUT;
			MODE_FLASH:     return LVL_START_FLASH;
			default:        return level;
		endcase
	endfunction

	task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Track registers and level, queue predictions, retire results
	always @(posedge clk or negedge arst_n) begin
		colour_t got;
		colour_t want;
		if (!arst_n) begin
			regs.mode        = MODE_FADE_IN;
			regs.duration_ms = DURATION_RESET;
			regs.flash_red   = 8'd0;
			regs.flash_green = 8'd0;
			regs.flash_blue  = 8'd0;
			level            = LVL_START_FADE_IN;
			colours_due.delete();
			mismatches       = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {red_out, green_out, blue_out};
				if (colours_due.size() == 0) begin
					$display("%0t: result word %0d %0d %0d with nothing expected", $time,
						got.red, got.green, got.blue);
					mismatches++;
				end else begin
					want = colours_due.pop_front();
					report_field("red_out", want.red, got.red);
					report_field("green_out", want.green, got.green);
					report_field("blue_out", want.blue, got.blue);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:        regs.mode        = cfg_data[2:0];
					CFG_DURATION:    regs.duration_ms = cfg_data;
					CFG_FLASH_RED:   regs.flash_red   = cfg_data[7:0];
					CFG_FLASH_GREEN: regs.flash_green = cfg_data[7:0];
					CFG_FLASH_BLUE:  regs.flash_blue  = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (op)
					OP_COLOUR: begin
						want.red   = blend_component(red_in, regs.flash_red);
						want.green = blend_component(green_in, regs.flash_green);
						want.blue  = blend_component(blue_in, regs.flash_blue);
						colours_due.push_back(want);
					end
					OP_TICK:    level = level_after_tick(frame_ms);
					OP_RESTART: level = start_level_of(regs.mode);
					default: ;
				endcase
			end
		end
		colours_pending = colours_due.size();
	end

endmodule
`default_nettype wire

@@ verif/tb_palette_fade_flash_blender.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_palette_fade_flash_blender
// Drives the palette fade and flash blender with a directed opening, a long
// output hold-off and sixteen random phases of varied register settings and
// idling, while a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_palette_fade_flash_blender;
	import pfb_pkg::*;

	localparam logic [1:0]           OP_UNUSED          = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST    = 3'd7;
	localparam int                   PHASES             = 16;
	localparam int                   WORDS_PER_PHASE    = 78;
	localparam int                   SETTLE_CYCLES      = 200;
	localparam int                   STALL_BURST_CYCLES = 400;
	localparam int                   LIMIT_CYCLES       = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            op;
	logic [7:0]            red_in;
	logic [7:0]            green_in;
	logic [7:0]            blue_in;
	logic [7:0]            frame_ms;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int colours_pending;
	int send_idle_pct;
	int stall_pct;
	bit stall_burst_req;
	int cycles;

	palette_fade_flash_blender i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.frame_ms  (frame_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pfb_blend_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.frame_ms        (frame_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.colours_pending (colours_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_palette_fade_flash_blender failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int burst_left;
		burst_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_burst_req) begin
				stall_burst_req = 1'b0;
				burst_left = STALL_BURST_CYCLES;
			end
			if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one word after an optional idle gap; return once it is taken
	task automatic send_word(input logic [1:0] o, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		frame_ms <= ms;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Hold a register write until it is taken; valid stays high for a burst
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic release_cfg();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, drain all results, then let ticks in flight finish
	task automatic settle();
		in_valid <= 1'b0;
		while (colours_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int         roll;
		logic [1:0] rnd_op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] ms;
		logic [2:0] phase_mode;
		logic [15:0] phase_dur;
		logic [7:0] fr;
		logic [7:0] fg;
		logic [7:0] fb;

		in_valid        <= 1'b0;
		op              <= OP_COLOUR;
		red_in          <= 8'd0;
		green_in        <= 8'd0;
		blue_in         <= 8'd0;
		frame_ms        <= 8'd0;
		cfg_valid       <= 1'b0;
		cfg_index       <= CFG_MODE;
		cfg_data        <= '0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		stall_burst_req = 1'b0;
		arst_n          <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: solid black, then through the band, then pass
		send_word(OP_COLOUR, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_COLOUR, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd255);
		send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd255);
		send_word(OP_COLOUR, 8'd255, 8'd0, 8'd128, 8'd0);
		repeat (4) send_word(OP_TICK, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(OP_COLOUR, 8'd200, 8'd100, 8'd50, 8'd0);
		send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd255);
		send_word(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(OP_RESTART, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_COLOUR, 8'd17, 8'd34, 8'd51, 8'd0);
		settle();

		// Fade out with zero duration
		write_reg(CFG_MODE, 16'(MODE_FADE_OUT));
		write_reg(CFG_DURATION, 16'd0);
		release_cfg();
		send_word(OP_RESTART, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_COLOUR, 8'd255, 8'd255, 8'd255, 8'd0);
		settle();

		// Flash entered without a restart: level far below the band
		write_reg(CFG_MODE, 16'(MODE_FLASH));
		write_reg(CFG_DURATION, DURATION_RESET);
		write_reg(CFG_FLASH_RED, 16'd255);
		write_reg(CFG_FLASH_GREEN, 16'd0);
		write_reg(CFG_FLASH_BLUE, 16'd170);
		release_cfg();
		send_word(OP_COLOUR, 8'd0, 8'd255, 8'd85, 8'd0);
		send_word(OP_RESTART, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd255);
		send_word(OP_COLOUR, 8'd100, 8'd200, 8'd30, 8'd0);
		settle();

		// White out: pass at zero, solid white after a full step
		write_reg(CFG_MODE, 16'(MODE_WHITE_OUT));
		write_reg(CFG_DURATION, 16'd0);
		release_cfg();
		send_word(OP_RESTART, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_COLOUR, 8'd0, 8'd128, 8'd255, 8'd0);
		send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd1);
		send_word(OP_COLOUR, 8'd0, 8'd128, 8'd255, 8'd0);
		settle();

		// Hold the output off while words keep coming, so the input stalls
		stall_burst_req = 1'b1;
		repeat (40)
			send_word(OP_COLOUR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			// Pick this phase's registers, extremes included
			phase_mode = (p < 8) ? 3'(p) : 3'($urandom_range(MODE_FADE_IN, MODE_FLASH));
			case (p % 6)
				0: phase_dur = DURATION_RESET;
				1: phase_dur = 16'd1;
				2: phase_dur = 16'd0;
				3: phase_dur = 16'hffff;
				4: phase_dur = 16'($urandom_range(16, 400));
				default: phase_dur = 16'($urandom_range(1, 65535));
			endcase
			case (p % 3)
				0: begin fr = 8'd0;   fg = 8'd0;   fb = 8'd0;   end
				1: begin fr = 8'd255; fg = 8'd255; fb = 8'd255; end
				default: begin fr = 8'($urandom); fg = 8'($urandom); fb = 8'($urandom); end
			endcase
			write_reg(CFG_MODE, {13'($urandom), phase_mode});
			write_reg(CFG_DURATION, phase_dur);
			write_reg(CFG_FLASH_RED, {8'($urandom), fr});
			write_reg(CFG_FLASH_GREEN, {8'($urandom), fg});
			write_reg(CFG_FLASH_BLUE, {8'($urandom), fb});
			write_reg(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)), 16'($urandom));
			release_cfg();

			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 58; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 58; end
				default: begin send_idle_pct = 9; stall_pct = 9; end
			endcase

			// Usually start the effect afresh; sometimes keep the old level
			if ($urandom_range(3) != 0)
				send_word(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				r  = 8'($urandom);
				g  = 8'($urandom);
				b  = 8'($urandom);
				ms = 8'($urandom);
				if (roll < 60) begin
					rnd_op = OP_COLOUR;
					if ($urandom_range(9) == 0) begin
						r = $urandom_range(1) ? 8'hff : 8'h00;
						g = $urandom_range(1) ? 8'hff : 8'h00;
						b = $urandom_range(1) ? 8'hff : 8'h00;
					end
				end else if (roll < 85) begin
					rnd_op = OP_TICK;
					// mostly frame-sized steps, so the level crosses the band
					if ($urandom_range(9) < 7)
						ms = 8'($urandom_range(1, 40));
				end else if (roll < 95) begin
					rnd_op = OP_RESTART;
				end else begin
					rnd_op = OP_UNUSED;
				end
				send_word(rnd_op, r, g, b, ms);
			end
			settle();
		end

		if (mismatches == 0)
			$display("tb_palette_fade_flash_blender passed");
		else
			$display("tb_palette_fade_flash_blender failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/pfb_pkg.sv
rtl/pfb_front.sv
rtl/pfb_div.sv
rtl/pfb_back.sv
rtl/palette_fade_flash_blender.sv
verif/pfb_blend_checker.sv
verif/tb_palette_fade_flash_blender.sv
